>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the root finder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset
`define BRF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset
`define BRF_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/brf_pkg.sv
// Types, constants, saturating arithmetic and microprogram of the root finder.
package brf_pkg;

   localparam int DW = 64;
   localparam int FB = 32;
   localparam int PC_W = 7;
   localparam int RA_W = 5;
   localparam int RF_DEPTH = 32;

   typedef logic [DW-1:0] word_type;

   localparam word_type WMAX = {1'b0, {(DW-1){1'b1}}};
   localparam word_type WMIN = {1'b1, {(DW-1){1'b0}}};
   localparam word_type ONE_Q = word_type'(1) << FB;

   // configuration register indexes
   localparam logic [1:0] CSR_HALF_TOL = 2'd0;
   localparam logic [1:0] CSR_MAX_ITER = 2'd1;

   // result status codes
   localparam logic [1:0] RS_EVAL      = 2'd0;
   localparam logic [1:0] RS_ROOT      = 2'd1;
   localparam logic [1:0] RS_NOBRACKET = 2'd2;
   localparam logic [1:0] RS_LIMIT     = 2'd3;

   // register file slots
   localparam logic [RA_W-1:0] RG_A    = 5'd0;
   localparam logic [RA_W-1:0] RG_B    = 5'd1;
   localparam logic [RA_W-1:0] RG_C    = 5'd2;
   localparam logic [RA_W-1:0] RG_FA   = 5'd3;
   localparam logic [RA_W-1:0] RG_FB   = 5'd4;
   localparam logic [RA_W-1:0] RG_FC   = 5'd5;
   localparam logic [RA_W-1:0] RG_D    = 5'd6;
   localparam logic [RA_W-1:0] RG_E    = 5'd7;
   localparam logic [RA_W-1:0] RG_M    = 5'd8;
   localparam logic [RA_W-1:0] RG_TM   = 5'd9;
   localparam logic [RA_W-1:0] RG_S    = 5'd10;
   localparam logic [RA_W-1:0] RG_P    = 5'd11;
   localparam logic [RA_W-1:0] RG_Q    = 5'd12;
   localparam logic [RA_W-1:0] RG_Q1   = 5'd13;
   localparam logic [RA_W-1:0] RG_R    = 5'd14;
   localparam logic [RA_W-1:0] RG_T    = 5'd15;
   localparam logic [RA_W-1:0] RG_U    = 5'd16;
   localparam logic [RA_W-1:0] RG_L1   = 5'd17;
   localparam logic [RA_W-1:0] RG_L2   = 5'd18;
   localparam logic [RA_W-1:0] RG_ZERO = 5'd19;
   localparam logic [RA_W-1:0] RG_ONE  = 5'd20;
   localparam logic [RA_W-1:0] RG_TOL  = 5'd21;

   // load sources
   localparam logic [RA_W-1:0] SRC_PL   = 5'd0;
   localparam logic [RA_W-1:0] SRC_PH   = 5'd1;
   localparam logic [RA_W-1:0] SRC_VL   = 5'd2;
   localparam logic [RA_W-1:0] SRC_VH   = 5'd3;
   localparam logic [RA_W-1:0] SRC_FV   = 5'd4;
   localparam logic [RA_W-1:0] SRC_ZERO = 5'd5;
   localparam logic [RA_W-1:0] SRC_ONE  = 5'd6;
   localparam logic [RA_W-1:0] SRC_TOL  = 5'd7;

   // microprogram entry points
   localparam logic [PC_W-1:0] PC_START = 7'd0;
   localparam logic [PC_W-1:0] PC_VALUE = 7'd13;

   typedef enum logic [3:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOV, OP_ABS, OP_HALF, OP_LDIN, OP_BR, OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      CND_ALWAYS, CND_LT, CND_MAGLT, CND_MAGLE, CND_EQ, CND_SAME, CND_GTZ, CND_LIMIT
   } cond_type;

   typedef enum logic [2:0] {
      FS_IDLE, FS_FETCH, FS_EXEC, FS_WAIT, FS_EMIT
   } fsm_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic              inv;
      logic [RA_W-1:0]   dst;
      logic [RA_W-1:0]   x;
      logic [RA_W-1:0]   y;
      logic [PC_W-1:0]   tgt;
      logic [1:0]        rs;
   } instr_type;

   typedef struct packed {
      logic      capture;
      logic      clear_count;
      logic      inc_count;
      logic      alu_write;
      logic      mul_start;
      logic      div_start;
      logic      unit_write;
      logic      emit;
      instr_type instr;
   } cmd_type;

   typedef struct packed {
      logic cond_true;
      logic unit_done;
      logic out_free;
   } stat_type;

   // magnitude, 2^63 for the most negative value
   function automatic word_type mag(word_type x);
      return x[DW-1] ? (~x + word_type'(1)) : x;
   endfunction

   function automatic word_type sat_signed(logic neg, word_type m, logic ovf);
      if (ovf) return neg ? WMIN : WMAX;
      if (!neg) return m[DW-1] ? WMAX : m;
      if (m[DW-1]) return WMIN;
      return ~m + word_type'(1);
   endfunction

   function automatic word_type sat_add(word_type x, word_type y);
      logic [DW:0] s;
      s = {x[DW-1], x} + {y[DW-1], y};
      if (s[DW] != s[DW-1]) return s[DW] ? WMIN : WMAX;
      return s[DW-1:0];
   endfunction

   function automatic word_type sat_sub(word_type x, word_type y);
      logic [DW:0] s;
      s = {x[DW-1], x} - {y[DW-1], y};
      if (s[DW] != s[DW-1]) return s[DW] ? WMIN : WMAX;
      return s[DW-1:0];
   endfunction

   // (x - y) / 2, exact, truncated toward zero
   function automatic word_type half_diff(word_type x, word_type y);
      logic [DW:0] d;
      word_type r;
      d = {x[DW-1], x} - {y[DW-1], y};
      r = d[DW:1];
      if (d[DW] && d[0]) r = r + word_type'(1);
      return r;
   endfunction

   function automatic instr_type i_alu(op_type op, logic [RA_W-1:0] dst,
                                       logic [RA_W-1:0] x, logic [RA_W-1:0] y);
      instr_type r;
      r = '0;
      r.op = op; r.cond = CND_ALWAYS; r.dst = dst; r.x = x; r.y = y;
      return r;
   endfunction

   function automatic instr_type i_br(cond_type cond, logic inv, logic [RA_W-1:0] x,
                                      logic [RA_W-1:0] y, logic [PC_W-1:0] tgt);
      instr_type r;
      r = '0;
      r.op = OP_BR; r.cond = cond; r.inv = inv; r.x = x; r.y = y; r.tgt = tgt;
      return r;
   endfunction

   function automatic instr_type i_emit(logic [1:0] rs, logic [RA_W-1:0] x);
      instr_type r;
      r = '0;
      r.op = OP_EMIT; r.cond = CND_ALWAYS; r.x = x; r.rs = rs;
      return r;
   endfunction

   // Brent iteration microprogram
   function automatic instr_type brf_rom(logic [PC_W-1:0] pc);
      instr_type r;
      case (pc)
         // start: load bracket and constants, check the bracket, set d and e
         7'd0:  r = i_alu(OP_LDIN, RG_A, SRC_PL, RG_A);
         7'd1:  r = i_alu(OP_LDIN, RG_B, SRC_PH, RG_A);
         7'd2:  r = i_alu(OP_LDIN, RG_FA, SRC_VL, RG_A);
         7'd3:  r = i_alu(OP_LDIN, RG_FB, SRC_VH, RG_A);
         7'd4:  r = i_alu(OP_LDIN, RG_C, SRC_PL, RG_A);
         7'd5:  r = i_alu(OP_LDIN, RG_FC, SRC_VL, RG_A);
         7'd6:  r = i_alu(OP_LDIN, RG_ZERO, SRC_ZERO, RG_A);
         7'd7:  r = i_alu(OP_LDIN, RG_ONE, SRC_ONE, RG_A);
         7'd8:  r = i_alu(OP_LDIN, RG_TOL, SRC_TOL, RG_A);
         7'd9:  r = i_br(CND_SAME, 1'b0, RG_FA, RG_FB, 7'd82);
         7'd10: r = i_alu(OP_SUB, RG_D, RG_B, RG_A);
         7'd11: r = i_alu(OP_MOV, RG_E, RG_D, RG_D);
         7'd12: r = i_br(CND_ALWAYS, 1'b0, RG_A, RG_A, 7'd14);
         // new function value
         7'd13: r = i_alu(OP_LDIN, RG_FB, SRC_FV, RG_A);
         // iteration
         7'd14: r = i_br(CND_LIMIT, 1'b0, RG_A, RG_A, 7'd81);
         7'd15: r = i_br(CND_SAME, 1'b1, RG_FB, RG_FC, 7'd20);
         7'd16: r = i_alu(OP_MOV, RG_C, RG_A, RG_A);
         7'd17: r = i_alu(OP_MOV, RG_FC, RG_FA, RG_FA);
         7'd18: r = i_alu(OP_SUB, RG_D, RG_B, RG_A);
         7'd19: r = i_alu(OP_MOV, RG_E, RG_D, RG_D);
         7'd20: r = i_br(CND_MAGLT, 1'b1, RG_FC, RG_FB, 7'd27);
         7'd21: r = i_alu(OP_MOV, RG_A, RG_B, RG_B);
         7'd22: r = i_alu(OP_MOV, RG_FA, RG_FB, RG_FB);
         7'd23: r = i_alu(OP_MOV, RG_B, RG_C, RG_C);
         7'd24: r = i_alu(OP_MOV, RG_FB, RG_FC, RG_FC);
         7'd25: r = i_alu(OP_MOV, RG_C, RG_A, RG_A);
         7'd26: r = i_alu(OP_MOV, RG_FC, RG_FA, RG_FA);
         7'd27: r = i_alu(OP_HALF, RG_M, RG_C, RG_B);
         7'd28: r = i_br(CND_MAGLE, 1'b0, RG_M, RG_TOL, 7'd80);
         7'd29: r = i_br(CND_EQ, 1'b0, RG_FB, RG_ZERO, 7'd80);
         7'd30: r = i_br(CND_MAGLT, 1'b0, RG_E, RG_TOL, 7'd68);
         7'd31: r = i_br(CND_MAGLT, 1'b1, RG_FB, RG_FA, 7'd68);
         7'd32: r = i_alu(OP_DIV, RG_S, RG_FB, RG_FA);
         7'd33: r = i_alu(OP_ADD, RG_TM, RG_M, RG_M);
         7'd34: r = i_br(CND_EQ, 1'b1, RG_A, RG_C, 7'd38);
         // secant
         7'd35: r = i_alu(OP_MUL, RG_P, RG_TM, RG_S);
         7'd36: r = i_alu(OP_SUB, RG_Q, RG_ONE, RG_S);
         7'd37: r = i_br(CND_ALWAYS, 1'b0, RG_A, RG_A, 7'd52);
         // inverse quadratic interpolation
         7'd38: r = i_alu(OP_DIV, RG_Q1, RG_FA, RG_FC);
         7'd39: r = i_alu(OP_DIV, RG_R, RG_FB, RG_FC);
         7'd40: r = i_alu(OP_MUL, RG_T, RG_TM, RG_Q1);
         7'd41: r = i_alu(OP_SUB, RG_U, RG_Q1, RG_R);
         7'd42: r = i_alu(OP_MUL, RG_T, RG_T, RG_U);
         7'd43: r = i_alu(OP_SUB, RG_U, RG_B, RG_A);
         7'd44: r = i_alu(OP_SUB, RG_L1, RG_R, RG_ONE);
         7'd45: r = i_alu(OP_MUL, RG_U, RG_U, RG_L1);
         7'd46: r = i_alu(OP_SUB, RG_T, RG_T, RG_U);
         7'd47: r = i_alu(OP_MUL, RG_P, RG_S, RG_T);
         7'd48: r = i_alu(OP_SUB, RG_U, RG_Q1, RG_ONE);
         7'd49: r = i_alu(OP_MUL, RG_U, RG_U, RG_L1);
         7'd50: r = i_alu(OP_SUB, RG_L2, RG_S, RG_ONE);
         7'd51: r = i_alu(OP_MUL, RG_Q, RG_U, RG_L2);
         // acceptance test of the interpolated step
         7'd52: r = i_br(CND_GTZ, 1'b1, RG_P, RG_P, 7'd54);
         7'd53: r = i_alu(OP_SUB, RG_Q, RG_ZERO, RG_Q);
         7'd54: r = i_alu(OP_ABS, RG_P, RG_P, RG_P);
         7'd55: r = i_alu(OP_ADD, RG_U, RG_TM, RG_M);
         7'd56: r = i_alu(OP_MUL, RG_L1, RG_U, RG_Q);
         7'd57: r = i_alu(OP_MUL, RG_U, RG_TOL, RG_Q);
         7'd58: r = i_alu(OP_ABS, RG_U, RG_U, RG_U);
         7'd59: r = i_alu(OP_SUB, RG_L1, RG_L1, RG_U);
         7'd60: r = i_alu(OP_MUL, RG_U, RG_E, RG_Q);
         7'd61: r = i_alu(OP_ABS, RG_L2, RG_U, RG_U);
         7'd62: r = i_alu(OP_ADD, RG_U, RG_P, RG_P);
         7'd63: r = i_br(CND_LT, 1'b1, RG_U, RG_L1, 7'd68);
         7'd64: r = i_br(CND_LT, 1'b1, RG_U, RG_L2, 7'd68);
         7'd65: r = i_alu(OP_MOV, RG_E, RG_D, RG_D);
         7'd66: r = i_alu(OP_DIV, RG_D, RG_P, RG_Q);
         7'd67: r = i_br(CND_ALWAYS, 1'b0, RG_A, RG_A, 7'd70);
         // bisection
         7'd68: r = i_alu(OP_MOV, RG_D, RG_M, RG_M);
         7'd69: r = i_alu(OP_MOV, RG_E, RG_M, RG_M);
         // take the step
         7'd70: r = i_alu(OP_MOV, RG_A, RG_B, RG_B);
         7'd71: r = i_alu(OP_MOV, RG_FA, RG_FB, RG_FB);
         7'd72: r = i_br(CND_MAGLT, 1'b1, RG_TOL, RG_D, 7'd75);
         7'd73: r = i_alu(OP_ADD, RG_B, RG_B, RG_D);
         7'd74: r = i_br(CND_ALWAYS, 1'b0, RG_A, RG_A, 7'd79);
         7'd75: r = i_br(CND_GTZ, 1'b0, RG_M, RG_M, 7'd78);
         7'd76: r = i_alu(OP_SUB, RG_B, RG_B, RG_TOL);
         7'd77: r = i_br(CND_ALWAYS, 1'b0, RG_A, RG_A, 7'd79);
         7'd78: r = i_alu(OP_ADD, RG_B, RG_B, RG_TOL);
         // results
         7'd79: r = i_emit(RS_EVAL, RG_B);
         7'd80: r = i_emit(RS_ROOT, RG_B);
         7'd81: r = i_emit(RS_LIMIT, RG_B);
         7'd82: r = i_emit(RS_NOBRACKET, RG_ZERO);
         default: r = i_emit(RS_LIMIT, RG_B);
      endcase
      return r;
   endfunction

endpackage

>>> rtl/brent_root_finder.sv
// Brent root finder top level: one iteration per start or function-value beat.
// Each beat runs microinstructions, serial multiplies and up to four divisions (interpolating step).
// Throughput: one beat at a time; the next beat can be taken in the cycle the result appears.
// Reset (synchronous, active high) goes idle, half_tolerance 1, max_iterations 500.
module brent_root_finder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic signed [63:0] req_point_low,
   input  logic signed [63:0] req_point_high,
   input  logic signed [63:0] req_value_low,
   input  logic signed [63:0] req_value_high,
   input  logic signed [63:0] req_func_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [63:0] rsp_point,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [32:0]        csr_data
);
   import brf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   brf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .stat          (stat),
      .cmd           (cmd)
   );

   brf_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_point_low  (req_point_low),
      .req_point_high (req_point_high),
      .req_value_low  (req_value_low),
      .req_value_high (req_value_high),
      .req_func_value (req_func_value),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_point      (rsp_point)
   );

endmodule

>>> rtl/brf_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module brf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

>>> rtl/brf_datapath.sv
// Datapath: register file, ALU, serial multiplier and divider, config and result registers.
module brf_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  brf_pkg::cmd_type        cmd,
   output brf_pkg::stat_type       stat,
   input  logic signed [63:0]      req_point_low,
   input  logic signed [63:0]      req_point_high,
   input  logic signed [63:0]      req_value_low,
   input  logic signed [63:0]      req_value_high,
   input  logic signed [63:0]      req_func_value,
   input  logic                    csr_valid,
   input  logic [1:0]              csr_index,
   input  logic [32:0]             csr_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic signed [63:0]      rsp_point
);
   import brf_pkg::*;

   word_type pl_ff, ph_ff, vl_ff, vh_ff, fv_ff;
   logic [32:0] half_tol_ff;
   logic [9:0]  max_iter_ff;
   logic [9:0]  count_ff;

   word_type opx, opy, alu_res, unit_res, wdata;
   logic     we;
   logic     cond_val;

   // multiplier state
   word_type    ma_ff, mb_ff;
   logic        mneg_ff;
   logic        mbusy_ff, mdone_ff;
   logic [2:0]  mcnt_ff;
   logic [63:0] pp_ff, pp_in;
   logic [1:0]  psh_ff;
   logic [127:0] acc_ff, pp_ext;
   logic [31:0] ahalf, bhalf;
   word_type    mul_res;

   // divider state
   word_type     dd_ff, rem_ff, quo_ff, dres_ff;
   logic [127:0] num_ff;
   logic         dneg_ff, dovf_ff;
   logic         dbusy_ff, dfin_ff, ddone_ff;
   logic [6:0]   dcnt_ff;
   logic [64:0]  rsh;
   logic         dge;

   logic         rsp_valid_ff;
   logic [1:0]   rsp_status_ff;
   word_type     rsp_point_ff;

   // input beat capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pl_ff <= req_point_low;
         ph_ff <= req_point_high;
         vl_ff <= req_value_low;
         vh_ff <= req_value_high;
         fv_ff <= req_func_value;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_tol_ff <= 33'd1;
         max_iter_ff <= 10'd500;
      end else if (csr_valid) begin
         if (csr_index == CSR_HALF_TOL) half_tol_ff <= csr_data;
         if (csr_index == CSR_MAX_ITER) max_iter_ff <= csr_data[9:0];
      end
   end

   // evaluation counter
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear_count) begin
         count_ff <= '0;
      end else if (cmd.inc_count) begin
         count_ff <= count_ff + 10'd1;
      end
   end

   // working registers
   assign we    = cmd.alu_write | cmd.unit_write;
   assign wdata = cmd.unit_write ? unit_res : alu_res;

   brf_ram #(.WIDTH(DW), .DEPTH(RF_DEPTH)) u_rf (
      .clock   (clock),
      .we      (we),
      .waddr   (cmd.instr.dst),
      .wdata   (wdata),
      .raddr_a (cmd.instr.x),
      .raddr_b (cmd.instr.y),
      .rdata_a (opx),
      .rdata_b (opy)
   );

   // combinational ALU operations
   always_comb begin
      unique case (cmd.instr.op)
         OP_ADD:  alu_res = sat_add(opx, opy);
         OP_SUB:  alu_res = sat_sub(opx, opy);
         OP_ABS:  alu_res = sat_signed(1'b0, mag(opx), 1'b0);
         OP_HALF: alu_res = half_diff(opx, opy);
         OP_LDIN: begin
            unique case (cmd.instr.x)
               SRC_PL:   alu_res = pl_ff;
               SRC_PH:   alu_res = ph_ff;
               SRC_VL:   alu_res = vl_ff;
               SRC_VH:   alu_res = vh_ff;
               SRC_FV:   alu_res = fv_ff;
               SRC_ONE:  alu_res = ONE_Q;
               SRC_TOL:  alu_res = {31'd0, half_tol_ff};
               default:  alu_res = '0;
            endcase
         end
         default: alu_res = opx;
      endcase
   end

   // branch conditions
   always_comb begin
      unique case (cmd.instr.cond)
         CND_ALWAYS: cond_val = 1'b1;
         CND_LT:     cond_val = $signed(opx) < $signed(opy);
         CND_MAGLT:  cond_val = mag(opx) < mag(opy);
         CND_MAGLE:  cond_val = mag(opx) <= mag(opy);
         CND_EQ:     cond_val = opx == opy;
         CND_SAME:   cond_val = ($signed(opx) > 0 && $signed(opy) > 0) ||
                                (opx[DW-1] && opy[DW-1]);
         CND_GTZ:    cond_val = $signed(opx) > 0;
         CND_LIMIT:  cond_val = count_ff >= max_iter_ff;
         default:    cond_val = 1'b0;
      endcase
   end

   // multiplier: four 32x32 partial products, then accumulate
   assign ahalf  = mcnt_ff[0] ? ma_ff[63:32] : ma_ff[31:0];
   assign bhalf  = mcnt_ff[1] ? mb_ff[63:32] : mb_ff[31:0];
   assign pp_in  = 64'(ahalf) * 64'(bhalf);
   always_comb begin
      unique case (psh_ff)
         2'd0:    pp_ext = {64'd0, pp_ff};
         2'd1:    pp_ext = {32'd0, pp_ff, 32'd0};
         default: pp_ext = {pp_ff, 64'd0};
      endcase
   end
   assign mul_res = sat_signed(mneg_ff, acc_ff[FB+DW-1:FB], |acc_ff[127:FB+DW]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         mdone_ff <= 1'b0;
         mcnt_ff  <= '0;
      end else begin
         mdone_ff <= 1'b0;
         if (cmd.mul_start) begin
            mbusy_ff <= 1'b1;
            mcnt_ff  <= '0;
         end else if (mbusy_ff) begin
            mcnt_ff <= mcnt_ff + 3'd1;
            if (mcnt_ff == 3'd4) begin
               mbusy_ff <= 1'b0;
               mdone_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_start) begin
         ma_ff   <= mag(opx);
         mb_ff   <= mag(opy);
         mneg_ff <= opx[DW-1] ^ opy[DW-1];
         acc_ff  <= '0;
      end else if (mbusy_ff) begin
         if (mcnt_ff != 3'd4) begin
            pp_ff  <= pp_in;
            psh_ff <= {1'b0, mcnt_ff[0]} + {1'b0, mcnt_ff[1]};
         end
         if (mcnt_ff != 3'd0) begin
            acc_ff <= acc_ff + pp_ext;
         end
      end
   end

   // divider: restoring, one quotient bit per cycle
   assign rsh = {rem_ff, num_ff[127]};
   assign dge = rsh[64] || (rsh[63:0] >= dd_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         dfin_ff  <= 1'b0;
         ddone_ff <= 1'b0;
         dcnt_ff  <= '0;
      end else begin
         ddone_ff <= dfin_ff;
         dfin_ff  <= 1'b0;
         if (cmd.div_start) begin
            if (opx == '0 || opy == '0) begin
               ddone_ff <= 1'b1;
            end else begin
               dbusy_ff <= 1'b1;
               dcnt_ff  <= 7'd127;
            end
         end else if (dbusy_ff) begin
            dcnt_ff <= dcnt_ff - 7'd1;
            if (dcnt_ff == 7'd0) begin
               dbusy_ff <= 1'b0;
               dfin_ff  <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         num_ff  <= {32'd0, mag(opx), 32'd0};
         dd_ff   <= mag(opy);
         rem_ff  <= '0;
         quo_ff  <= '0;
         dovf_ff <= 1'b0;
         dneg_ff <= opx[DW-1] ^ opy[DW-1];
         // zero dividend gives zero, zero divisor saturates by dividend sign
         if (opx == '0) dres_ff <= '0;
         else           dres_ff <= sat_signed(opx[DW-1], '0, 1'b1);
      end else if (dbusy_ff) begin
         num_ff <= {num_ff[126:0], 1'b0};
         rem_ff <= dge ? (rsh[63:0] - dd_ff) : rsh[63:0];
         quo_ff <= {quo_ff[62:0], dge};
         if (quo_ff[63]) dovf_ff <= 1'b1;
      end else if (dfin_ff) begin
         dres_ff <= sat_signed(dneg_ff, quo_ff, dovf_ff);
      end
   end

   assign unit_res = (cmd.instr.op == OP_MUL) ? mul_res : dres_ff;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= cmd.instr.rs;
         rsp_point_ff  <= opx;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_point  = rsp_point_ff;

   assign stat.cond_true = cond_val ^ cmd.instr.inv;
   assign stat.unit_done = mdone_ff | ddone_ff;
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

>>> rtl/brf_ctrl.sv
// Controller: microprogram sequencer state machine of the root finder.
module brf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  brf_pkg::stat_type  stat,
   output brf_pkg::cmd_type   cmd
);
   import brf_pkg::*;

   fsm_type         state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic            searching_ff, searching_in;
   instr_type       instr;
   logic            accept;

   assign instr     = brf_rom(pc_ff);
   assign req_stall = (state_ff != FS_IDLE);
   assign accept    = req_valid && (state_ff == FS_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FS_IDLE;
         pc_ff        <= '0;
         searching_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         searching_ff <= searching_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FS_IDLE: begin
            if (accept && (!req_operation || searching_ff)) state_in = FS_FETCH;
         end
         FS_FETCH: state_in = FS_EXEC;
         FS_EXEC: begin
            unique case (instr.op)
               OP_MUL, OP_DIV: state_in = FS_WAIT;
               OP_EMIT:        state_in = FS_EMIT;
               default:        state_in = FS_FETCH;
            endcase
         end
         FS_WAIT: begin
            if (stat.unit_done) state_in = FS_FETCH;
         end
         FS_EMIT: begin
            if (stat.out_free) state_in = FS_IDLE;
         end
         default: state_in = FS_IDLE;
      endcase
   end

   // commands, program counter, search flag
   always_comb begin
      cmd          = '0;
      cmd.instr    = instr;
      pc_in        = pc_ff;
      searching_in = searching_ff;
      unique case (state_ff)
         FS_IDLE: begin
            cmd.capture = accept;
            if (accept && !req_operation) begin
               cmd.clear_count = 1'b1;
               pc_in           = PC_START;
               searching_in    = 1'b1;
            end else if (accept) begin
               pc_in = PC_VALUE;
            end
         end
         FS_FETCH: ;
         FS_EXEC: begin
            unique case (instr.op)
               OP_BR:   pc_in = stat.cond_true ? instr.tgt : pc_ff + 7'd1;
               OP_MUL:  cmd.mul_start = 1'b1;
               OP_DIV:  cmd.div_start = 1'b1;
               OP_EMIT: ;
               default: begin
                  cmd.alu_write = 1'b1;
                  pc_in         = pc_ff + 7'd1;
               end
            endcase
         end
         FS_WAIT: begin
            if (stat.unit_done) begin
               cmd.unit_write = 1'b1;
               pc_in          = pc_ff + 7'd1;
            end
         end
         FS_EMIT: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.inc_count = (instr.rs == RS_EVAL);
               searching_in  = (instr.rs == RS_EVAL);
            end
         end
         default: ;
      endcase
   end

endmodule

>>> rtl/brf_checker.sv
// Port-level checker of the root finder and its bind to the top level.
`include "assert_macros.svh"

module brf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_operation,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_status,
   input logic signed [63:0] rsp_point
);
   import brf_pkg::*;

   // a stalled result beat holds
   `BRF_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_point) && $stable(rsp_status), "result beat changed under stall")

   // not-bracketed result carries a zero point
   `BRF_ASSERT_IMP(a_nb_zero, rsp_valid && rsp_status == RS_NOBRACKET, rsp_point == 64'sd0, "not-bracketed point nonzero")

   // an accepted start keeps the input busy next cycle
   `BRF_ASSERT_NXT(a_start_busy, req_valid && !req_stall && !req_operation, req_stall, "start beat not followed by busy")

   // no result appears the cycle after a beat is taken
   `BRF_ASSERT_NXT(a_no_instant, req_valid && !req_stall, !$rose(rsp_valid), "result too early after input beat")

endmodule

bind brent_root_finder brf_checker u_brf_checker (.*);
